// ===== rtl/core/asvg_pkg.sv =====
// ----------------------------------------------------------------------------
// asvg_pkg
// Shared types, codes and constants of the array steering vector generator.
// ----------------------------------------------------------------------------
package asvg_pkg;

  typedef enum logic [3:0] {
    S_IDLE,
    S_PREP,
    S_DIV0,
    S_ROT0,
    S_CHAN,
    S_DIVK,
    S_ROTK,
    S_MUL,
    S_SECT,
    S_ROTW,
    S_EMIT
  } asvg_state_t;

  localparam int DEF_WEIGHT_BITS = 16;

  localparam logic [1:0] REG_HEADING  = 2'd0;
  localparam logic [1:0] REG_CHANNELS = 2'd1;
  localparam logic [1:0] REG_GEOMETRY = 2'd2;
  localparam logic [1:0] REG_SPACING  = 2'd3;

  localparam logic [1:0] GEOM_LINEAR = 2'd0;
  localparam logic [1:0] GEOM_CIRC   = 2'd1;
  localparam logic [1:0] GEOM_NONE   = 2'd2;

  localparam logic [15:0] RST_HEADING  = 16'd0;
  localparam logic [4:0]  RST_CHANNELS = 5'd8;
  localparam logic [1:0]  RST_GEOMETRY = GEOM_LINEAR;
  localparam logic [15:0] RST_SPACING  = 16'd2048;

  localparam logic [4:0] CHAN_LIMIT = 5'd16;

  localparam logic [4:0] DIV_LAST  = 5'd23;
  localparam logic [4:0] ROT_LAST  = 5'd17;
  localparam logic [4:0] MUL_LAST  = 5'd19;
  localparam logic [4:0] SECT_LAST = 5'd3;

  localparam logic signed [32:0] CORDIC_GAIN = 33'sd652032874;

  // arctangent of 2^-i in 2^-24 turn
  function automatic logic [21:0] atan_turn(input logic [4:0] i);
    logic [21:0] a;
    case (i)
      5'd0:    a = 22'd2097152;
      5'd1:    a = 22'd1238021;
      5'd2:    a = 22'd654136;
      5'd3:    a = 22'd332050;
      5'd4:    a = 22'd166669;
      5'd5:    a = 22'd83416;
      5'd6:    a = 22'd41718;
      5'd7:    a = 22'd20860;
      5'd8:    a = 22'd10430;
      5'd9:    a = 22'd5215;
      5'd10:   a = 22'd2608;
      5'd11:   a = 22'd1304;
      5'd12:   a = 22'd652;
      5'd13:   a = 22'd326;
      5'd14:   a = 22'd163;
      5'd15:   a = 22'd81;
      5'd16:   a = 22'd41;
      5'd17:   a = 22'd20;
      default: a = 22'd0;
    endcase
    return a;
  endfunction

  // fold phase into the right half plane: {flip, residual}
  function automatic logic [26:0] cordic_init(input logic [23:0] p);
    logic signed [25:0] z;
    logic               f;
    z = $signed({2'b00, p});
    f = 1'b0;
    if (p[23] ^ p[22]) begin
      z = z - 26'sh0800000;
      f = 1'b1;
    end else if (p[23]) begin
      z = z - 26'sh1000000;
    end
    return {f, z};
  endfunction

endpackage

// ===== rtl/core/array_steering_vector_generator.sv =====
// ----------------------------------------------------------------------------
// array_steering_vector_generator
// One azimuth in, one complex steering weight per array channel out.
// ----------------------------------------------------------------------------
// One item at a time. Setup runs a fold, a bit-serial divide to the phase
// angle and a CORDIC pass. Each channel then runs, for a linear array, a
// bit-serial multiply, a CORDIC pass and the emit; for a circular channel
// past the centre, a divide for the element angle, two CORDIC passes, the
// multiply and a sector fold; for the centre, the sector fold, a CORDIC
// pass and the emit; for other geometries, only the emit. The shared
// iterative CORDIC, the restoring divider and the shift-add multiplier
// serve these steps; an output stall holds the emit.
// ----------------------------------------------------------------------------
module array_steering_vector_generator
  import asvg_pkg::*;
#(
  parameter int WEIGHT_BITS = DEF_WEIGHT_BITS
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [1:0]                    cfg_index,
  input  logic [15:0]                   cfg_wdata,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [15:0]                   in_azimuth,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [3:0]                    out_channel_index,
  output logic signed [WEIGHT_BITS-1:0] out_weight_real,
  output logic signed [WEIGHT_BITS-1:0] out_weight_imag,
  output logic                          out_last_channel,
  output logic                          out_behind_array,
  output logic                          out_blind_spot
);

  localparam logic signed [33:0] W_MAX = (34'sd1 <<< (WEIGHT_BITS - 1)) - 34'sd1;
  localparam logic signed [33:0] W_MIN = -(34'sd1 <<< (WEIGHT_BITS - 1));
  localparam logic signed [33:0] W_RND = 34'sd1 <<< (30 - WEIGHT_BITS);

  function automatic logic signed [WEIGHT_BITS-1:0] to_weight(
    input logic signed [32:0] v);
    logic signed [33:0] s;
    logic signed [33:0] r;
    s = {v[32], v} + W_RND;
    r = s >>> (31 - WEIGHT_BITS);
    if (r > W_MAX) r = W_MAX;
    if (r < W_MIN) r = W_MIN;
    return r[WEIGHT_BITS-1:0];
  endfunction

  logic [15:0] heading_r;
  logic [4:0]  chan_total_r;
  logic [1:0]  geom_r;
  logic [15:0] spacing_r;

  asvg_state_t state_r, state_nxt;
  logic [4:0]  cnt_r, cnt_nxt;

  logic signed [17:0] th_r, th_nxt;
  logic               behind_r, behind_nxt;
  logic               blind_r, blind_nxt;
  logic [3:0]         nlast_r, nlast_nxt;
  logic [3:0]         ch_r, ch_nxt;
  logic [19:0]        chsp_r, chsp_nxt;

  logic signed [23:0] base_r, base_nxt;
  logic signed [23:0] rel_r, rel_nxt;
  logic [19:0]        turnm_r, turnm_nxt;
  logic [19:0]        s300_r, s300_nxt;
  logic [19:0]        s60_r, s60_nxt;
  logic [19:0]        s120_r, s120_nxt;
  logic [19:0]        s240_r, s240_nxt;

  logic [16:0] rem_r, rem_nxt;
  logic [15:0] den_r, den_nxt;
  logic [23:0] cbits_r, cbits_nxt;
  logic [23:0] quo_r, quo_nxt;
  logic [23:0] ptheta_r, ptheta_nxt;

  logic signed [32:0] cx_r, cx_nxt;
  logic signed [32:0] cy_r, cy_nxt;
  logic signed [25:0] cz_r, cz_nxt;
  logic               cflip_r, cflip_nxt;
  logic signed [32:0] st_r, st_nxt;

  logic signed [41:0] mcand_r, mcand_nxt;
  logic signed [41:0] acc_r, acc_nxt;
  logic [19:0]        mplr_r, mplr_nxt;

  logic                          out_valid_r, out_valid_nxt;
  logic [3:0]                    out_ch_r, out_ch_nxt;
  logic signed [WEIGHT_BITS-1:0] out_wr_r, out_wr_nxt;
  logic signed [WEIGHT_BITS-1:0] out_wi_r, out_wi_nxt;
  logic                          out_last_r, out_last_nxt;
  logic                          out_behind_r, out_behind_nxt;
  logic                          out_blind_r, out_blind_nxt;

  logic emit_go;
  logic in_acc;
  logic last_ch;

  // divider step
  logic [17:0] dt;
  logic        dge;
  logic [17:0] drem;
  logic [23:0] dquo;

  // cordic step
  logic signed [32:0] xs, ys, sx, sy, fx, fy, rx, ry;
  logic signed [25:0] ang, sz;

  // multiplier step
  logic signed [41:0] macc, phw;

  // misc
  logic signed [17:0] diff;
  logic signed [18:0] tsum;
  logic [16:0]        t1, t2;
  logic signed [22:0] thm;
  logic               sect_on;
  logic [26:0]        cinit;

  assign in_acc  = in_valid && in_ready;
  assign last_ch = (ch_r == nlast_r);

  always_comb begin
    dt   = {rem_r, cbits_r[23]};
    dge  = (dt >= {2'b00, den_r});
    drem = dge ? (dt - {2'b00, den_r}) : dt;
    dquo = {quo_r[22:0], dge};

    xs  = cx_r >>> cnt_r;
    ys  = cy_r >>> cnt_r;
    ang = $signed({4'b0000, atan_turn(cnt_r)});
    if (!cz_r[25]) begin
      sx = cx_r - ys;
      sy = cy_r + xs;
      sz = cz_r - ang;
    end else begin
      sx = cx_r + ys;
      sy = cy_r - xs;
      sz = cz_r + ang;
    end
    fx = cflip_r ? -sx : sx;
    fy = cflip_r ? -sy : sy;
    rx = cflip_r ? -cx_r : cx_r;
    ry = cflip_r ? -cy_r : cy_r;

    macc = mplr_r[0] ? (acc_r + mcand_r) : acc_r;
    phw  = macc + 42'sd131072;

    sect_on = (rel_r > $signed({4'b0000, s300_r})) ||
              (rel_r < $signed({4'b0000, s60_r})) ||
              ((rel_r > $signed({4'b0000, s120_r})) &&
               (rel_r < $signed({4'b0000, s240_r})));

    diff = $signed({2'b00, in_azimuth}) - $signed({2'b00, heading_r});
    tsum = {th_r[17], th_r} + 19'sd92160;
    t1   = (tsum[16:0] >= 17'd46080) ? (tsum[16:0] - 17'd46080) : tsum[16:0];
    t2   = (t1 >= 17'd46080) ? (t1 - 17'd46080) : t1;
    thm  = th_r * $signed({1'b0, nlast_r});
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: if (in_valid) state_nxt = S_PREP;
      S_PREP: state_nxt = S_DIV0;
      S_DIV0: if (cnt_r == DIV_LAST) state_nxt = S_ROT0;
      S_ROT0: if (cnt_r == ROT_LAST) state_nxt = S_CHAN;
      S_CHAN: begin
        if (geom_r == GEOM_LINEAR) begin
          state_nxt = S_MUL;
        end else if (geom_r == GEOM_CIRC) begin
          state_nxt = (ch_r == 4'd0) ? S_SECT : S_DIVK;
        end else begin
          state_nxt = S_EMIT;
        end
      end
      S_DIVK: if (cnt_r == DIV_LAST) state_nxt = S_ROTK;
      S_ROTK: if (cnt_r == ROT_LAST) state_nxt = S_MUL;
      S_MUL: begin
        if (cnt_r == MUL_LAST) state_nxt = (geom_r == GEOM_CIRC) ? S_SECT : S_ROTW;
      end
      S_SECT: if (cnt_r == SECT_LAST) state_nxt = S_ROTW;
      S_ROTW: if (cnt_r == ROT_LAST) state_nxt = S_EMIT;
      S_EMIT: if (emit_go) state_nxt = last_ch ? S_IDLE : S_CHAN;
      default: state_nxt = S_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    in_ready = (state_r == S_IDLE);
    emit_go  = !out_valid_r || out_ready;
  end

  // datapath
  always_comb begin
    cnt_nxt    = (state_nxt != state_r) ? 5'd0 : cnt_r + 5'd1;
    th_nxt     = th_r;
    behind_nxt = behind_r;
    blind_nxt  = blind_r;
    nlast_nxt  = nlast_r;
    ch_nxt     = ch_r;
    chsp_nxt   = chsp_r;
    base_nxt   = base_r;
    rel_nxt    = rel_r;
    turnm_nxt  = turnm_r;
    s300_nxt   = s300_r;
    s60_nxt    = s60_r;
    s120_nxt   = s120_r;
    s240_nxt   = s240_r;
    rem_nxt    = rem_r;
    den_nxt    = den_r;
    cbits_nxt  = cbits_r;
    quo_nxt    = quo_r;
    ptheta_nxt = ptheta_r;
    cx_nxt     = cx_r;
    cy_nxt     = cy_r;
    cz_nxt     = cz_r;
    cflip_nxt  = cflip_r;
    st_nxt     = st_r;
    mcand_nxt  = mcand_r;
    acc_nxt    = acc_r;
    mplr_nxt   = mplr_r;
    cinit      = cordic_init(24'd0);

    out_valid_nxt  = out_ready ? 1'b0 : out_valid_r;
    out_ch_nxt     = out_ch_r;
    out_wr_nxt     = out_wr_r;
    out_wi_nxt     = out_wi_r;
    out_last_nxt   = out_last_r;
    out_behind_nxt = out_behind_r;
    out_blind_nxt  = out_blind_r;

    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          behind_nxt = 1'b0;
          th_nxt     = diff;
          if (diff >= 18'sd34560) begin
            th_nxt = diff - 18'sd46080;
          end else if (diff > 18'sd11520) begin
            th_nxt     = diff - 18'sd23040;
            behind_nxt = 1'b1;
          end
          blind_nxt = (geom_r == GEOM_LINEAR) && (th_nxt > 18'sd10240) &&
                      (th_nxt < 18'sd35840);
          if (chan_total_r < 5'd2) begin
            nlast_nxt = 4'd1;
          end else if (chan_total_r > CHAN_LIMIT) begin
            nlast_nxt = 4'(CHAN_LIMIT - 5'd1);
          end else begin
            nlast_nxt = 4'(chan_total_r - 5'd1);
          end
        end
      end
      S_PREP: begin
        rem_nxt   = t2;
        den_nxt   = 16'd46080;
        cbits_nxt = 24'd23040;
        quo_nxt   = 24'd0;
        base_nxt  = {thm[22], thm};
        turnm_nxt = 20'(nlast_r) * 20'd46080;
        s300_nxt  = 20'(nlast_r) * 20'd38400;
        s60_nxt   = 20'(nlast_r) * 20'd7680;
        s120_nxt  = 20'(nlast_r) * 20'd15360;
        s240_nxt  = 20'(nlast_r) * 20'd30720;
        chsp_nxt  = 20'd0;
        ch_nxt    = 4'd0;
      end
      S_DIV0, S_DIVK: begin
        rem_nxt   = drem[16:0];
        cbits_nxt = {cbits_r[22:0], 1'b0};
        quo_nxt   = dquo;
        if (cnt_r == DIV_LAST) begin
          if (state_r == S_DIV0) begin
            ptheta_nxt = dquo;
            cinit      = cordic_init(dquo);
          end else begin
            cinit = cordic_init(ptheta_r - dquo);
          end
          cx_nxt    = CORDIC_GAIN;
          cy_nxt    = 33'sd0;
          cflip_nxt = cinit[26];
          cz_nxt    = $signed(cinit[25:0]);
        end
      end
      S_ROT0, S_ROTK, S_ROTW: begin
        cx_nxt = sx;
        cy_nxt = sy;
        cz_nxt = sz;
        if (cnt_r == ROT_LAST) begin
          if (state_r == S_ROT0) st_nxt = fy;
          if (state_r == S_ROTK) begin
            mcand_nxt = {{9{fx[32]}}, fx};
            mplr_nxt  = {4'b0000, spacing_r};
            acc_nxt   = 42'sd0;
          end
        end
      end
      S_CHAN: begin
        rel_nxt = base_r;
        if (geom_r == GEOM_LINEAR) begin
          mcand_nxt = {{9{st_r[32]}}, st_r};
          mplr_nxt  = chsp_r;
          acc_nxt   = 42'sd0;
        end else if (geom_r == GEOM_CIRC) begin
          if (ch_r == 4'd0) begin
            cinit     = cordic_init(24'd0);
            cx_nxt    = CORDIC_GAIN;
            cy_nxt    = 33'sd0;
            cflip_nxt = cinit[26];
            cz_nxt    = $signed(cinit[25:0]);
          end else begin
            rem_nxt   = {13'd0, ch_r - 4'd1};
            den_nxt   = {12'd0, nlast_r};
            cbits_nxt = {21'd0, nlast_r[3:1]};
            quo_nxt   = 24'd0;
          end
        end
      end
      S_MUL: begin
        acc_nxt   = macc;
        mcand_nxt = mcand_r <<< 1;
        mplr_nxt  = {1'b0, mplr_r[19:1]};
        if (cnt_r == MUL_LAST) begin
          cinit     = cordic_init(phw[41:18]);
          cx_nxt    = CORDIC_GAIN;
          cy_nxt    = 33'sd0;
          cflip_nxt = cinit[26];
          cz_nxt    = $signed(cinit[25:0]);
        end
      end
      S_SECT: begin
        if (rel_r[23]) rel_nxt = rel_r + $signed({4'b0000, turnm_r});
      end
      S_EMIT: begin
        if (emit_go) begin
          out_valid_nxt  = 1'b1;
          out_ch_nxt     = ch_r;
          out_last_nxt   = last_ch;
          out_behind_nxt = behind_r;
          out_blind_nxt  = blind_r;
          out_wr_nxt     = '0;
          out_wi_nxt     = '0;
          if ((geom_r == GEOM_LINEAR) || ((geom_r == GEOM_CIRC) && sect_on)) begin
            out_wr_nxt = to_weight(rx);
            out_wi_nxt = to_weight(ry);
          end
          base_nxt = base_r - 24'sd46080;
          chsp_nxt = chsp_r + {4'b0000, spacing_r};
          ch_nxt   = ch_r + 4'd1;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      heading_r    <= RST_HEADING;
      chan_total_r <= RST_CHANNELS;
      geom_r       <= RST_GEOMETRY;
      spacing_r    <= RST_SPACING;
      state_r      <= S_IDLE;
      cnt_r        <= 5'd0;
      out_valid_r  <= 1'b0;
      ch_r         <= 4'd0;
      nlast_r      <= 4'd1;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_HEADING:  heading_r    <= cfg_wdata;
          REG_CHANNELS: chan_total_r <= cfg_wdata[4:0];
          REG_GEOMETRY: geom_r       <= cfg_wdata[1:0];
          REG_SPACING:  spacing_r    <= cfg_wdata;
          default:      heading_r    <= heading_r;
        endcase
      end
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
      ch_r        <= ch_nxt;
      nlast_r     <= nlast_nxt;
    end
  end

  always_ff @(posedge clk) begin
    th_r         <= th_nxt;
    behind_r     <= behind_nxt;
    blind_r      <= blind_nxt;
    chsp_r       <= chsp_nxt;
    base_r       <= base_nxt;
    rel_r        <= rel_nxt;
    turnm_r      <= turnm_nxt;
    s300_r       <= s300_nxt;
    s60_r        <= s60_nxt;
    s120_r       <= s120_nxt;
    s240_r       <= s240_nxt;
    rem_r        <= rem_nxt;
    den_r        <= den_nxt;
    cbits_r      <= cbits_nxt;
    quo_r        <= quo_nxt;
    ptheta_r     <= ptheta_nxt;
    cx_r         <= cx_nxt;
    cy_r         <= cy_nxt;
    cz_r         <= cz_nxt;
    cflip_r      <= cflip_nxt;
    st_r         <= st_nxt;
    mcand_r      <= mcand_nxt;
    acc_r        <= acc_nxt;
    mplr_r       <= mplr_nxt;
    out_ch_r     <= out_ch_nxt;
    out_wr_r     <= out_wr_nxt;
    out_wi_r     <= out_wi_nxt;
    out_last_r   <= out_last_nxt;
    out_behind_r <= out_behind_nxt;
    out_blind_r  <= out_blind_nxt;
  end

  assign out_valid         = out_valid_r;
  assign out_channel_index = out_ch_r;
  assign out_weight_real   = out_wr_r;
  assign out_weight_imag   = out_wi_r;
  assign out_last_channel  = out_last_r;
  assign out_behind_array  = out_behind_r;
  assign out_blind_spot    = out_blind_r;

  a_div_rem: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == S_DIV0) || (state_r == S_DIVK)) |-> (rem_r < {1'b0, den_r}))
    else $error("divider remainder not below divisor");

  a_ch_range: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r != S_IDLE) && (state_r != S_PREP)) |-> (ch_r <= nlast_r))
    else $error("channel counter past last channel");

  a_mid_beat: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_ready && !out_last_r) |-> (state_r != S_IDLE))
    else $error("idle before last channel beat");

endmodule
